/* rtl/timestamped_ring_range_query_core_assert.svh */
// Assertion macros used by the checker file of the ring range query core.
`ifndef TIMESTAMPED_RING_RANGE_QUERY_CORE_ASSERT_SVH
`define TIMESTAMPED_RING_RANGE_QUERY_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TRRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TRRQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/trrq_pkg.sv */
// Package with the constants and codes of the ring range query core.
package trrq_pkg;
    localparam int MAX_DEPTH_DEF = 1024;
    localparam int TIME_BITS_DEF = 63;
    localparam int CFG_W         = 11;
    localparam int CNT_W         = 11;
    localparam int TIME_W        = 63;
    localparam int VALUE_W       = 64;
    localparam int OP_W          = 2;

    localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
    localparam logic [OP_W-1:0] OP_RANGE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam logic [CFG_W-1:0] DEPTH_RESET = 11'd1024;
endpackage

/* rtl/trrq_store.sv */
// Sample store: time, value and flag memories with one write and one registered read port.
module trrq_store #(
    parameter int DEPTH = 1024,
    parameter int TW    = 63
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [$clog2(DEPTH)-1:0]    i_waddr,
    input  logic [TW-1:0]               i_wtime,
    input  logic [trrq_pkg::VALUE_W-1:0] i_wvalue,
    input  logic                        i_wflag,
    input  logic [$clog2(DEPTH)-1:0]    i_raddr,
    output logic [TW-1:0]               o_rtime,
    output logic [trrq_pkg::VALUE_W-1:0] o_rvalue,
    output logic                        o_rflag
);
    import trrq_pkg::*;

    logic [TW-1:0]      r_time_mem  [DEPTH];
    logic [VALUE_W-1:0] r_value_mem [DEPTH];
    logic               r_flag_mem  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_time_mem[i_waddr]  <= i_wtime;
            r_value_mem[i_waddr] <= i_wvalue;
            r_flag_mem[i_waddr]  <= i_wflag;
        end
        o_rtime  <= r_time_mem[i_raddr];
        o_rvalue <= r_value_mem[i_raddr];
        o_rflag  <= r_flag_mem[i_raddr];
    end
endmodule

/* rtl/timestamped_ring_range_query_core.sv */
// Top level of the timestamped ring store with binary-search range query.
//
//  channel | direction | handshake                | payload
//  input   | in        | i_valid / o_ready        | opcode, times, value, flag
//  result  | out       | o_valid / i_ready        | found, count, entry, empty, last
//  config  | in        | i_cfg_valid / o_cfg_ready | active depth
//
// A record or an unused opcode is answered straight from idle, a read passes a memory
// read state and an output state, and a range query binary-searches both ends; each
// probe has an address, a memory read and a compare step on the shared compare.
// Synchronous active-low reset; the store contents are not cleared.
// A new item is taken only after the previous result has been transferred.
module timestamped_ring_range_query_core #(
    parameter int MAX_DEPTH = trrq_pkg::MAX_DEPTH_DEF,
    parameter int TIME_BITS = trrq_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [trrq_pkg::OP_W-1:0]     i_opcode,
    input  logic [trrq_pkg::TIME_W-1:0]   i_sample_time,
    input  logic [trrq_pkg::TIME_W-1:0]   i_range_end_time,
    input  logic [trrq_pkg::VALUE_W-1:0]  i_sample_value,
    input  logic                          i_plottable,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_range_found,
    output logic [trrq_pkg::CNT_W-1:0]    o_range_count,
    output logic [trrq_pkg::TIME_W-1:0]   o_out_time,
    output logic [trrq_pkg::VALUE_W-1:0]  o_out_value,
    output logic                          o_out_plottable,
    output logic                          o_read_empty,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [trrq_pkg::CFG_W-1:0]    i_cfg_active_depth
);
    import trrq_pkg::*;

    localparam int IW = $clog2(MAX_DEPTH);
    localparam int DW = IW + 1;
    localparam int SW = IW + 2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INIT = 4'd1;
    localparam logic [3:0] S_F1   = 4'd2;
    localparam logic [3:0] S_C1   = 4'd3;
    localparam logic [3:0] S_F2   = 4'd4;
    localparam logic [3:0] S_C2   = 4'd5;
    localparam logic [3:0] S_MID  = 4'd6;
    localparam logic [3:0] S_FL   = 4'd7;
    localparam logic [3:0] S_CL   = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;
    localparam logic [3:0] S_RF   = 4'd10;
    localparam logic [3:0] S_RO   = 4'd11;

    logic [3:0]            r_state, n_state;
    logic [DW-1:0]         r_depth, n_depth;
    logic [IW-1:0]         r_newest, n_newest;
    logic [DW-1:0]         r_fill, n_fill;
    logic [IW-1:0]         r_first, n_first;
    logic [IW-1:0]         r_last, n_last;
    logic [IW-1:0]         r_rptr, n_rptr;
    logic [DW-1:0]         r_rem, n_rem;
    logic signed [SW-1:0]  r_a, n_a, r_b, n_b, r_i, n_i;
    logic [IW-1:0]         r_f, n_f;
    logic                  r_phase, n_phase;
    logic                  r_ok, n_ok;
    logic [IW-1:0]         r_addr, n_addr;
    logic [TIME_BITS-1:0]  r_tbeg, n_tbeg, r_tend, n_tend;
    logic                  r_ovalid, n_ovalid;
    logic                  r_o_found, n_o_found;
    logic [CNT_W-1:0]      r_o_count, n_o_count;
    logic [TIME_W-1:0]     r_o_time, n_o_time;
    logic [VALUE_W-1:0]    r_o_value, n_o_value;
    logic                  r_o_plot, n_o_plot;
    logic                  r_o_empty, n_o_empty;
    logic                  r_o_last, n_o_last;

    logic                  w_in_fire;
    logic                  w_we;
    logic [IW-1:0]         w_widx;
    logic [TIME_BITS-1:0]  w_in_time;
    logic [TIME_BITS-1:0]  w_tq;
    logic [VALUE_W-1:0]    w_vq;
    logic                  w_fq;
    logic [TIME_BITS-1:0]  w_target;
    logic                  w_lt, w_gt;
    logic signed [SW-1:0]  w_d;
    logic [DW-1:0]         w_cnt;

    assign w_in_fire = i_valid && o_ready;
    assign o_ready   = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready = 1'b1;

    assign w_widx = (({1'b0, r_newest} + DW'(1)) == r_depth) ? '0 : (r_newest + IW'(1));
    assign w_we   = w_in_fire && (i_opcode == OP_RECORD);
    assign w_in_time = TIME_BITS'(64'(i_sample_time));
    assign w_target  = r_phase ? r_tend : r_tbeg;
    assign w_lt = w_tq < w_target;
    assign w_gt = w_tq > w_target;
    assign w_d  = $signed({1'b0, r_depth});

    always_comb begin
        if (r_first == r_last) begin
            w_cnt = '0;
        end else if (r_first < r_last) begin
            w_cnt = {1'b0, r_last} - {1'b0, r_first} + DW'(1);
        end else begin
            w_cnt = r_depth - {1'b0, r_first} + {1'b0, r_last} + DW'(1);
        end
    end

    trrq_store #(
        .DEPTH (MAX_DEPTH),
        .TW    (TIME_BITS)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_widx),
        .i_wtime  (w_in_time),
        .i_wvalue (i_sample_value),
        .i_wflag  (i_plottable),
        .i_raddr  (r_addr),
        .o_rtime  (w_tq),
        .o_rvalue (w_vq),
        .o_rflag  (w_fq)
    );

    always_comb begin
        logic                 hit;
        logic [IW-1:0]        hit_idx;
        logic                 miss;
        logic signed [SW-1:0] na, nb, fi, sa;
        int unsigned          cv;

        n_state = r_state;   n_depth = r_depth;   n_newest = r_newest;
        n_fill = r_fill;     n_first = r_first;   n_last = r_last;
        n_rptr = r_rptr;     n_rem = r_rem;       n_a = r_a;
        n_b = r_b;           n_i = r_i;           n_f = r_f;
        n_phase = r_phase;   n_ok = r_ok;         n_addr = r_addr;
        n_tbeg = r_tbeg;     n_tend = r_tend;     n_ovalid = r_ovalid;
        n_o_found = r_o_found; n_o_count = r_o_count; n_o_time = r_o_time;
        n_o_value = r_o_value; n_o_plot = r_o_plot; n_o_empty = r_o_empty;
        n_o_last = r_o_last;
        hit = 1'b0;  hit_idx = '0;  miss = 1'b0;
        na = r_a;  nb = r_b;  fi = r_i;
        sa = $signed({2'b0, r_newest}) - $signed({1'b0, r_fill}) + SW'(1);
        cv = 32'(i_cfg_active_depth);

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_o_found = 1'b0;  n_o_count = '0;  n_o_time = '0;
                    n_o_value = '0;    n_o_plot = 1'b0; n_o_empty = 1'b0;
                    n_o_last = 1'b0;
                    unique case (i_opcode)
                        OP_RECORD: begin
                            n_newest = w_widx;
                            if (r_fill < r_depth) begin
                                n_fill = r_fill + DW'(1);
                            end
                            n_ovalid = 1'b1;
                        end
                        OP_RANGE: begin
                            n_tbeg  = w_in_time;
                            n_tend  = TIME_BITS'(64'(i_range_end_time));
                            n_phase = 1'b0;
                            if (r_fill == '0) begin
                                n_first = r_last;
                                n_ok    = 1'b0;
                                n_state = S_FIN;
                            end else begin
                                n_state = S_INIT;
                            end
                        end
                        OP_READ: begin
                            if (r_rem == '0) begin
                                n_o_empty = 1'b1;
                                n_ovalid  = 1'b1;
                            end else begin
                                n_addr  = r_rptr;
                                n_state = S_RF;
                            end
                        end
                        OP_NONE: begin
                            n_ovalid = 1'b1;
                        end
                        default: begin
                            n_ovalid = 1'b1;
                        end
                    endcase
                end
            end
            S_INIT: begin
                if (sa < 0) begin
                    sa = sa + w_d;
                end
                n_a = sa;
                n_b = $signed({2'b0, r_newest});
                n_addr = r_phase ? sa[IW-1:0] : r_newest;
                n_state = S_F1;
            end
            S_F1: n_state = S_C1;
            S_C1: begin
                if (!r_phase ? w_lt : w_gt) begin
                    miss = 1'b1;
                end else if (!w_lt && !w_gt) begin
                    hit = 1'b1;
                    hit_idx = r_addr;
                end else if (r_a > r_b) begin
                    n_addr  = IW'(r_depth - DW'(1));
                    n_state = S_F2;
                end else begin
                    n_state = S_MID;
                end
            end
            S_F2: n_state = S_C2;
            S_C2: begin
                if (w_gt) begin
                    n_b = w_d - SW'(1);
                    n_state = S_MID;
                end else if (w_lt) begin
                    n_a = '0;
                    n_state = S_MID;
                end else begin
                    hit = 1'b1;
                    hit_idx = r_addr;
                end
            end
            S_MID: begin
                fi = r_a + ((r_b - r_a) >>> 1);
                n_i = fi;
                n_addr = fi[IW-1:0];
                n_state = S_FL;
            end
            S_FL: n_state = S_CL;
            S_CL: begin
                if (w_gt) begin
                    nb = r_i - SW'(1);
                end else if (w_lt) begin
                    na = r_i + SW'(1);
                end
                n_a = na;
                n_b = nb;
                if (!w_lt && !w_gt) begin
                    hit = 1'b1;
                    hit_idx = r_addr;
                end else if (na <= nb) begin
                    n_state = S_MID;
                end else begin
                    if (w_lt) begin
                        fi = !r_phase ? r_i + SW'(1) : r_i;
                    end else begin
                        fi = !r_phase ? r_i : r_i - SW'(1);
                    end
                    if (fi < 0) begin
                        fi = fi + w_d;
                    end
                    if (fi >= w_d) begin
                        fi = fi - w_d;
                    end
                    hit = 1'b1;
                    hit_idx = fi[IW-1:0];
                end
            end
            S_FIN: begin
                n_o_found = r_ok;
                n_o_count = CNT_W'(w_cnt);
                n_rptr  = r_first;
                n_rem   = w_cnt;
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            S_RF: n_state = S_RO;
            S_RO: begin
                n_o_time  = TIME_W'(64'(w_tq));
                n_o_value = w_vq;
                n_o_plot  = w_fq;
                n_o_last  = (r_rem == DW'(1));
                n_rem     = r_rem - DW'(1);
                n_rptr    = (({1'b0, r_rptr} + DW'(1)) == r_depth) ? '0 : (r_rptr + IW'(1));
                n_ovalid  = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (hit) begin
            if (!r_phase) begin
                n_f = hit_idx;
                n_phase = 1'b1;
                n_state = S_INIT;
            end else begin
                n_first = r_f;
                n_last  = hit_idx;
                n_ok    = 1'b1;
                n_state = S_FIN;
            end
        end
        if (miss) begin
            n_first = r_last;
            n_ok    = 1'b0;
            n_state = S_FIN;
        end

        if (i_cfg_valid) begin
            if (cv < 32'd2) begin
                cv = 32'd2;
            end
            if (cv > 32'(MAX_DEPTH)) begin
                cv = 32'(MAX_DEPTH);
            end
            n_depth  = DW'(cv);
            n_newest = '0;
            n_fill   = '0;
            n_first  = '0;
            n_last   = '0;
            n_rptr   = '0;
            n_rem    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_depth  <= DW'(32'(MAX_DEPTH) < 32'(DEPTH_RESET) ? 32'(MAX_DEPTH)
                                                             : 32'(DEPTH_RESET));
            r_newest <= '0;
            r_fill   <= '0;
            r_first  <= '0;
            r_last   <= '0;
            r_rptr   <= '0;
            r_rem    <= '0;
            r_phase  <= 1'b0;
            r_ok     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_depth  <= n_depth;
            r_newest <= n_newest;
            r_fill   <= n_fill;
            r_first  <= n_first;
            r_last   <= n_last;
            r_rptr   <= n_rptr;
            r_rem    <= n_rem;
            r_phase  <= n_phase;
            r_ok     <= n_ok;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a       <= n_a;
        r_b       <= n_b;
        r_i       <= n_i;
        r_f       <= n_f;
        r_addr    <= n_addr;
        r_tbeg    <= n_tbeg;
        r_tend    <= n_tend;
        r_o_found <= n_o_found;
        r_o_count <= n_o_count;
        r_o_time  <= n_o_time;
        r_o_value <= n_o_value;
        r_o_plot  <= n_o_plot;
        r_o_empty <= n_o_empty;
        r_o_last  <= n_o_last;
    end

    assign o_valid         = r_ovalid;
    assign o_range_found   = r_o_found;
    assign o_range_count   = r_o_count;
    assign o_out_time      = r_o_time;
    assign o_out_value     = r_o_value;
    assign o_out_plottable = r_o_plot;
    assign o_read_empty    = r_o_empty;
    assign o_last          = r_o_last;
endmodule

/* rtl/trrq_checker.sv */
// Port-level checker for the ring range query core, with its bind statement.
`include "timestamped_ring_range_query_core_assert.svh"

module trrq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic                          o_range_found,
    input logic [trrq_pkg::CNT_W-1:0]    o_range_count,
    input logic [trrq_pkg::TIME_W-1:0]   o_out_time,
    input logic                          o_read_empty,
    input logic                          o_last
);
    import trrq_pkg::*;

    `TRRQ_ASSERT_IMP(a_no_take_while_full, i_clk, i_rst_n, o_valid, !o_ready)
    `TRRQ_ASSERT_NXT(a_result_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `TRRQ_ASSERT_IMP(a_empty_no_data, i_clk, i_rst_n, o_valid && o_read_empty, (o_out_time == '0) && !o_last && !o_range_found)
    `TRRQ_ASSERT_IMP(a_miss_zero_count, i_clk, i_rst_n, o_valid && !o_range_found, o_range_count == '0)
endmodule

bind timestamped_ring_range_query_core trrq_checker u_trrq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_range_found (o_range_found),
    .o_range_count (o_range_count),
    .o_out_time    (o_out_time),
    .o_read_empty  (o_read_empty),
    .o_last        (o_last)
);
